// ===== rtl/lir_pkg.sv =====
// shared constants and state codes for the linear interpolation resampler
package lir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int STEP_W   = 20;
    localparam int PHASE_W  = 21;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int MULB_W   = FRAC_W + 1;
    localparam int PROD_W   = DIFF_W + MULB_W;
    localparam int MAX_OUT  = 16;
    localparam int CNT_W    = $clog2(MAX_OUT);

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_W;
    localparam logic [STEP_W-1:0]  STEP_ONE  = STEP_W'(1) << FRAC_W;
    localparam logic [STEP_W-1:0]  STEP_MIN  = STEP_ONE >> 4;
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAX_OUT - 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_START = 3'd1;
    localparam logic [ST_W-1:0] S_CALC  = 3'd2;
    localparam logic [ST_W-1:0] S_LOAD  = 3'd3;
    localparam logic [ST_W-1:0] S_BYP   = 3'd4;

endpackage

// ===== rtl/linear_interp_resampler.sv =====
// top level of the linear interpolation resampler
//
// input channel: in_valid / in_stall with sample_in, one signed sample per
// transaction. output channel: out_valid / out_stall with sample_out and
// run_last; run_last marks the final output produced by one input sample.
// rate_step is written through rate_step_we / rate_step_wdata; the user must
// write it only while idle, and the block does not enforce this. each input
// produces zero to 16 outputs. one output takes a pass through the shared
// multiplier loop (product in the calc state, then add and phase update in
// the load state); an input with no output goes back to idle from the start
// state, and a bypass input (step of exactly one) goes through the bypass
// state. in_stall is high while a sample is in work.
// a finished output sits in the output register while out_stall is high; the
// sequencer holds the next one in the load or bypass step until it is taken.
// reset clears the previous sample to zero, the phase to one and the step
// to one, and empties the output register.
module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rate_step_we,
    input  logic [STEP_W-1:0]          rate_step_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       run_last
);

    logic [STEP_W-1:0]          step_reg;
    logic [ST_W-1:0]            state_reg, state_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                       run_last_reg, run_last_next;

    logic                       in_fire;
    logic                       out_free;
    logic [STEP_W-1:0]          step_eff;
    logic [PHASE_W-1:0]         phase_sum;
    logic                       is_last;
    logic                       mul_en;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [MULB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SAMPLE_W+1:0] y_sum;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign step_eff  = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
    assign phase_sum = phase_reg + PHASE_W'(step_eff);
    assign is_last   = (phase_sum >= PHASE_ONE) || (cnt_reg == CNT_LAST);

    assign diff   = DIFF_W'(x_reg) - DIFF_W'(prev_reg);
    assign mul_b  = $signed({1'b0, phase_reg[FRAC_W-1:0]});
    assign mul_en = (state_reg == S_CALC);
    assign y_sum  = (SAMPLE_W+2)'(prev_reg) + prod[PROD_W-1:FRAC_W];

    lir_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (diff),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        sample_out_next = sample_out_reg;
        run_last_next   = run_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_START;
                    cnt_next   = '0;
                end
            end
            S_START:
            begin
                if (step_reg == STEP_ONE)
                begin
                    state_next = S_BYP;
                end
                else if (phase_reg >= PHASE_ONE)
                begin
                    phase_next = phase_reg - PHASE_ONE;
                    prev_next  = x_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = y_sum[SAMPLE_W-1:0];
                    run_last_next   = is_last;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    if (is_last)
                    begin
                        phase_next = (phase_sum >= PHASE_ONE) ? phase_sum - PHASE_ONE : '0;
                        prev_next  = x_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_sum;
                        state_next = S_CALC;
                    end
                end
            end
            S_BYP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = x_reg;
                    run_last_next   = 1'b1;
                    prev_next       = x_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_ONE;
            phase_reg     <= PHASE_ONE;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (rate_step_we)
            begin
                step_reg <= rate_step_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= sample_in;
        end
        sample_out_reg <= sample_out_next;
        run_last_reg   <= run_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign run_last   = run_last_reg;

    // interpolation only runs with the phase inside the current interval
    a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (phase_reg < PHASE_ONE))
        else $error("phase out of interval during interpolation");

    // between samples the phase stays below the step range
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (phase_reg[PHASE_W-1] == 1'b0))
        else $error("phase overflow between samples");

    // an accepted transaction always starts the sequencer
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_START))
        else $error("accepted sample did not start");

    // new outputs only come from the load or bypass steps
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_LOAD || $past(state_reg) == S_BYP))
        else $error("output appeared without a load");

endmodule

// ===== rtl/lir_mul.sv =====
// shared signed multiplier with registered product
module lir_mul
    import lir_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DIFF_W-1:0] op_a,
    input  logic signed [MULB_W-1:0] op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule
